@@ rtl/core/sbr_pkg.sv @@
// Shared types and constants of the stream byte reassembler.
package sbr_pkg;

	localparam int unsigned WINDOW_DEPTH_DEF = 64;
	localparam int unsigned MAX_RESULTS      = 64;
	localparam int unsigned DRAIN_CNT_W      = 7;
	localparam int unsigned PEND_OUT_W       = 7;
	localparam int unsigned IDX_W            = 64;
	localparam int unsigned CAP_W            = 17;
	localparam int unsigned SLOT_MAX_W       = 16;
	localparam int unsigned CMD_FIFO_DEPTH   = 4;

	typedef struct packed {
		logic [IDX_W-1:0] seg_start_index;
		logic [7:0]       data_byte;
		logic             byte_valid;
		logic             segment_end;
		logic             final_segment;
		logic [CAP_W-1:0] avail_capacity;
	} sbr_in_t;

	typedef struct packed {
		logic [7:0]            out_byte;
		logic                  out_valid;
		logic                  stream_close;
		logic [PEND_OUT_W-1:0] pending_bytes;
		logic                  run_last;
	} sbr_out_t;

	// Work handed from the front to the back: an optional store and an optional drain.
	typedef struct packed {
		logic                  wr;
		logic [SLOT_MAX_W-1:0] slot;
		logic [7:0]            data;
		logic                  drain;
		logic                  end_known;
		logic [IDX_W-1:0]      limit;
	} sbr_cmd_t;

	typedef struct packed {
		logic                  init_done;
		logic                  drain_done;
		logic [IDX_W-1:0]      next_expected;
		logic [SLOT_MAX_W-1:0] next_slot;
	} sbr_status_t;

endpackage

@@ rtl/core/sbr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module sbr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/sbr_front.sv @@
// Front end: accepts segment items, tracks the segment and window, classifies bytes.
module sbr_front
	import sbr_pkg::*;
#(
	parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seg_valid,
	output logic        seg_ready,
	input  sbr_in_t     seg,
	input  sbr_status_t status,
	output logic        cmd_push,
	output sbr_cmd_t    cmd,
	input  logic        cmd_full
);

	localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
	localparam int unsigned SUM_W  = SLOT_W + 1;
	localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(WINDOW_DEPTH);
	localparam logic [IDX_W-1:0] DEPTH_I = IDX_W'(WINDOW_DEPTH);

	logic             in_seg_q;
	logic [IDX_W-1:0] offset_q;
	logic [IDX_W-1:0] limit_q;
	logic             end_known_q;
	logic             end_pend_q;

	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] lim_s1;
	logic [7:0]       data_s1;
	logic             bvld_s1;
	logic             send_s1;
	logic             final_s1;

	logic             accept;
	logic             first;
	logic [IDX_W-1:0] off;
	logic [IDX_W:0]   sum_cap;
	logic [IDX_W-1:0] lim_sat;
	logic [IDX_W-1:0] lim_cur;
	logic [IDX_W-1:0] idx_cur;

	logic [IDX_W-1:0] diff;
	logic             hit;
	logic [SUM_W-1:0] slot_sum;
	logic [SUM_W-1:0] slot_red;
	logic [IDX_W-1:0] fin_limit;
	logic             end_known_new;
	logic [IDX_W-1:0] limit_new;
	logic             need_push;
	logic             s1_move;

	// accept stage
	assign first   = !in_seg_q;
	assign off     = first ? '0 : offset_q;
	assign sum_cap = {1'b0, status.next_expected} + (IDX_W + 1)'(seg.avail_capacity);
	assign lim_sat = sum_cap[IDX_W] ? '1 : sum_cap[IDX_W-1:0];
	assign lim_cur = (first && !end_known_q) ? lim_sat : limit_q;
	assign idx_cur = seg.seg_start_index + off;

	// classify stage
	assign diff = idx_s1 - status.next_expected;
	assign hit  = bvld_s1 && (idx_s1 >= status.next_expected) && (idx_s1 < lim_s1) &&
		(diff < DEPTH_I);
	assign slot_sum = {1'b0, status.next_slot[SLOT_W-1:0]} + {1'b0, diff[SLOT_W-1:0]};
	assign slot_red = (slot_sum >= DEPTH_S) ? slot_sum - DEPTH_S : slot_sum;

	assign fin_limit     = idx_s1 + IDX_W'(bvld_s1);
	assign end_known_new = end_known_q | final_s1;
	assign limit_new     = final_s1 ? fin_limit : lim_s1;

	assign need_push = vld_s1 && (hit || send_s1);
	assign s1_move   = !vld_s1 || !need_push || !cmd_full;
	assign cmd_push  = need_push && !cmd_full;

	assign cmd.wr        = hit;
	assign cmd.slot      = SLOT_MAX_W'(slot_red[SLOT_W-1:0]);
	assign cmd.data      = data_s1;
	assign cmd.drain     = send_s1;
	assign cmd.end_known = end_known_new;
	assign cmd.limit     = limit_new;

	// hold off new items during the reset sweep, while a drain is in flight and while the classify stage is stalled
	assign seg_ready = status.init_done && !end_pend_q && s1_move;
	assign accept    = seg_valid && seg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_seg_q    <= 1'b0;
			offset_q    <= '0;
			limit_q     <= '0;
			end_known_q <= 1'b0;
			end_pend_q  <= 1'b0;
			vld_s1      <= 1'b0;
		end else begin
			if (accept) begin
				in_seg_q <= !seg.segment_end;
				offset_q <= off + IDX_W'(seg.byte_valid);
				limit_q  <= lim_cur;
				vld_s1   <= 1'b1;
			end else if (s1_move) begin
				vld_s1 <= 1'b0;
			end
			if (vld_s1 && s1_move && send_s1) begin
				end_known_q <= end_known_new;
				limit_q     <= limit_new;
			end
			if (accept && seg.segment_end) begin
				end_pend_q <= 1'b1;
			end else if (status.drain_done) begin
				end_pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1   <= idx_cur;
			lim_s1   <= lim_cur;
			data_s1  <= seg.data_byte;
			bvld_s1  <= seg.byte_valid;
			send_s1  <= seg.segment_end;
			final_s1 <= seg.final_segment;
		end
	end

	a_end_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && send_s1) |-> end_pend_q)
		else $error("segment end in classify stage without drain lock");

endmodule

@@ rtl/core/sbr_cmd_fifo.sv @@
// Short command queue between the front end and the back end.
module sbr_cmd_fifo
	import sbr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  sbr_cmd_t push_data,
	output logic     full,
	input  logic     pop,
	output sbr_cmd_t pop_data,
	output logic     empty
);

	localparam int unsigned PTR_W = $clog2(CMD_FIFO_DEPTH);
	localparam int unsigned CNT_W = $clog2(CMD_FIFO_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CMD_FIFO_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CMD_FIFO_DEPTH);

	sbr_cmd_t         entry_q [CMD_FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == FULL_CNT);
	assign empty    = (cnt_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !(push && !pop))
		else $error("command queue overflow");

endmodule

@@ rtl/core/sbr_back.sv @@
// Back end: stores bytes in the window memory and drains the in-order run.
module sbr_back
	import sbr_pkg::*;
#(
	parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_empty,
	input  sbr_cmd_t    cmd,
	output logic        cmd_pop,
	output sbr_status_t status,
	output logic        res_valid,
	input  logic        res_ready,
	output sbr_out_t    res
);

	localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
	localparam int unsigned PEND_W = $clog2(WINDOW_DEPTH + 1);
	localparam int unsigned WORD_W = 9;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
	localparam logic [DRAIN_CNT_W-1:0] CNT_MAX = DRAIN_CNT_W'(MAX_RESULTS);
	localparam logic [PEND_W-1:0] PEND_MAX = PEND_W'(WINDOW_DEPTH);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_RUN,
		ST_WAIT,
		ST_RD,
		ST_CK
	} state_t;

	state_t                 state_q;
	logic [SLOT_W-1:0]      clr_q;
	logic [IDX_W-1:0]       ne_q;
	logic [SLOT_W-1:0]      ne_slot_q;
	logic [PEND_W-1:0]      pend_q;
	logic                   wvld_s1;
	logic [SLOT_W-1:0]      wslot_s1;
	logic [7:0]             wdata_s1;
	logic                   fwd_vld_q;
	logic [SLOT_W-1:0]      fwd_slot_q;
	logic                   ek_q;
	logic [IDX_W-1:0]       lim_q;
	logic [DRAIN_CNT_W-1:0] cnt_q;
	logic                   hold_vld_q;
	logic [7:0]             hold_byte_q;
	logic [PEND_W-1:0]      hold_pend_q;
	logic                   res_vld_q;
	sbr_out_t               res_q;

	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic              ram_re;
	logic [SLOT_W-1:0] ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	logic              out_free;
	logic              present_s1;
	logic              s1_wr;
	logic              more;
	logic              adv;
	logic              fin;
	logic              close;
	logic              res_load;
	logic [PEND_W-1:0] pend_dec;
	logic [PEND_W-1:0] pend_next;

	sbr_ram #(
		.WIDTH(WORD_W),
		.DEPTH(WINDOW_DEPTH)
	) u_window (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign out_free = !res_vld_q || res_ready;

	// a store issued the cycle before is not yet in the read data: forward it
	assign present_s1 = ram_rdata[WORD_W-1] || (fwd_vld_q && (fwd_slot_q == wslot_s1));
	assign s1_wr      = wvld_s1 && !present_s1;

	assign cmd_pop = (state_q == ST_RUN) && !cmd_empty && (!cmd.drain || !wvld_s1);

	assign more  = ram_rdata[WORD_W-1] && (cnt_q < CNT_MAX);
	assign adv   = (state_q == ST_CK) && more && (!hold_vld_q || out_free);
	assign fin   = (state_q == ST_CK) && !more && out_free;
	assign close = ek_q && (ne_q == lim_q);

	// a new result enters the output register when a held byte is released or the run ends
	assign res_load = (adv && hold_vld_q) || fin;

	assign pend_dec  = (pend_q != '0) ? pend_q - 1'b1 : pend_q;
	assign pend_next = adv ? pend_dec : (s1_wr ? pend_q + 1'b1 : pend_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wslot_s1;
		ram_wdata = {1'b1, wdata_s1};
		if (state_q == ST_INIT) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (s1_wr) begin
			ram_we = 1'b1;
		end else if (adv) begin
			ram_we    = 1'b1;
			ram_waddr = ne_slot_q;
			ram_wdata = '0;
		end
	end

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = cmd.slot[SLOT_W-1:0];
		if (cmd_pop && cmd.wr) begin
			ram_re = 1'b1;
		end else if (state_q == ST_RD) begin
			ram_re    = 1'b1;
			ram_raddr = ne_slot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			clr_q       <= '0;
			ne_q        <= '0;
			ne_slot_q   <= '0;
			pend_q      <= '0;
			wvld_s1     <= 1'b0;
			wslot_s1    <= '0;
			wdata_s1    <= '0;
			fwd_vld_q   <= 1'b0;
			fwd_slot_q  <= '0;
			ek_q        <= 1'b0;
			lim_q       <= '0;
			cnt_q       <= '0;
			hold_vld_q  <= 1'b0;
			hold_byte_q <= '0;
			hold_pend_q <= '0;
			res_vld_q   <= 1'b0;
			res_q       <= '0;
		end else begin
			pend_q     <= pend_next;
			fwd_vld_q  <= s1_wr;
			fwd_slot_q <= wslot_s1;
			wvld_s1    <= cmd_pop && cmd.wr;
			if (cmd_pop) begin
				wslot_s1 <= cmd.slot[SLOT_W-1:0];
				wdata_s1 <= cmd.data;
			end
			res_vld_q <= res_load || (res_vld_q && !res_ready);

			unique case (state_q)
				ST_INIT: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_SLOT) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd_pop && cmd.drain) begin
						ek_q    <= cmd.end_known;
						lim_q   <= cmd.limit;
						cnt_q   <= '0;
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_CK;
				end
				ST_CK: begin
					if (adv) begin
						// release the held byte, keep this one until the run end is known
						if (hold_vld_q) begin
							res_q <= '{out_byte: hold_byte_q, out_valid: 1'b1,
								stream_close: 1'b0,
								pending_bytes: PEND_OUT_W'(hold_pend_q), run_last: 1'b0};
						end
						hold_vld_q  <= 1'b1;
						hold_byte_q <= ram_rdata[7:0];
						hold_pend_q <= pend_dec;
						ne_q        <= ne_q + 1'b1;
						ne_slot_q   <= (ne_slot_q == LAST_SLOT) ? '0 : ne_slot_q + 1'b1;
						cnt_q       <= cnt_q + 1'b1;
						state_q     <= ST_RD;
					end else if (fin) begin
						if (hold_vld_q) begin
							res_q <= '{out_byte: hold_byte_q, out_valid: 1'b1,
								stream_close: close,
								pending_bytes: PEND_OUT_W'(hold_pend_q), run_last: 1'b1};
						end else begin
							res_q <= '{out_byte: 8'd0, out_valid: 1'b0,
								stream_close: close,
								pending_bytes: PEND_OUT_W'(pend_q), run_last: 1'b1};
						end
						hold_vld_q <= 1'b0;
						state_q    <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	assign res_valid = res_vld_q;
	assign res       = res_q;

	assign status.init_done     = (state_q != ST_INIT);
	assign status.drain_done    = fin;
	assign status.next_expected = ne_q;
	assign status.next_slot     = SLOT_MAX_W'(ne_slot_q);

	a_hold_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		hold_vld_q |-> (state_q == ST_RD || state_q == ST_CK))
		else $error("held byte outside a drain");

	a_store_not_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		wvld_s1 |-> !(state_q == ST_RD || state_q == ST_CK))
		else $error("store overlaps a drain read");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PEND_MAX)
		else $error("pending count exceeds window");

	a_drain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("drain released too many bytes");

endmodule

@@ rtl/core/stream_byte_reassembler_unit.sv @@
// Stream byte reassembler: takes segment bytes one per transaction on the seg channel and
// releases the in-order stream on the res channel. After reset the window memory is swept
// clear slot by slot, during which seg_ready stays low. The front end classifies each byte
// item against the window and queues a store, and unless the queue is full it can take a
// new byte item while the last one is still being classified; the back end performs one
// store per cycle while it is not draining. The end item of a segment locks the seg channel
// until its drain is finished: the drain waits for queued stores, then walks the window
// memory slot by slot (read, then check and release) and releases at most MAX_RESULTS bytes.
// The lock lasts longer while stores are still queued or res_ready is held low. Every end
// item produces at least one result; the last result of an end item carries run_last, and
// stream_close once the known stream end has been reached.
module stream_byte_reassembler_unit
	import sbr_pkg::*;
#(
	parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     seg_valid,
	output logic     seg_ready,
	input  sbr_in_t  seg,
	output logic     res_valid,
	input  logic     res_ready,
	output sbr_out_t res
);

	sbr_status_t status;
	sbr_cmd_t    push_cmd;
	sbr_cmd_t    head_cmd;
	logic        cmd_push;
	logic        cmd_pop;
	logic        cmd_full;
	logic        cmd_empty;

	// front: segment tracking, window limit and byte classification
	sbr_front #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.seg_valid(seg_valid),
		.seg_ready(seg_ready),
		.seg      (seg),
		.status   (status),
		.cmd_push (cmd_push),
		.cmd      (push_cmd),
		.cmd_full (cmd_full)
	);

	// queue: decouple classification from memory work
	sbr_cmd_fifo u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_data(push_cmd),
		.full     (cmd_full),
		.pop      (cmd_pop),
		.pop_data (head_cmd),
		.empty    (cmd_empty)
	);

	// back: window memory, pending count and in-order drain
	sbr_back #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd      (head_cmd),
		.cmd_pop  (cmd_pop),
		.status   (status),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

endmodule

@@ tb/sv/sbr_stream_checker.sv @@
// Checker for the stream byte reassembler: predicts the released stream and compares results.
module sbr_stream_checker
	import sbr_pkg::*;
#(
	parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     seg_valid,
	input  logic     seg_ready,
	input  sbr_in_t  seg,
	input  logic     res_valid,
	input  logic     res_ready,
	input  sbr_out_t res,
	output int       fail_count,
	output int       results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0]       win_data [WINDOW_DEPTH];
	logic             win_present [WINDOW_DEPTH];
	logic [IDX_W-1:0] next_idx;
	logic [IDX_W-1:0] limit_idx;
	logic [IDX_W-1:0] seg_pos;
	int unsigned      stored_cnt;
	logic             end_seen;
	logic             mid_segment;
	sbr_out_t         release_q [$];

	// Absorb one segment item; on an end item, queue the bytes it releases.
	function automatic void reassemble_item(input sbr_in_t it);
		logic [IDX_W:0]   sum;
		logic [IDX_W-1:0] idx;
		int unsigned      slot;
		int unsigned      n;
		logic             close;
		sbr_out_t         r;
		n = 0;
		if (!mid_segment) begin
			mid_segment = 1'b1;
			seg_pos     = '0;
			if (!end_seen) begin
				sum       = {1'b0, next_idx} + (IDX_W + 1)'(it.avail_capacity);
				limit_idx = sum[IDX_W] ? '1 : sum[IDX_W-1:0];
			end
		end
		if (it.byte_valid) begin
			idx = it.seg_start_index + seg_pos;
			if (idx >= next_idx && idx < limit_idx && idx - next_idx < WINDOW_DEPTH) begin
				slot = 32'(idx % WINDOW_DEPTH);
				if (!win_present[slot]) begin
					win_data[slot]    = it.data_byte;
					win_present[slot] = 1'b1;
					stored_cnt++;
				end
			end
			seg_pos++;
		end
		if (!it.segment_end)
			return;
		while (n < MAX_RESULTS && win_present[next_idx % WINDOW_DEPTH]) begin
			slot              = 32'(next_idx % WINDOW_DEPTH);
			r                 = '0;
			r.out_byte        = win_data[slot];
			r.out_valid       = 1'b1;
			win_present[slot] = 1'b0;
			next_idx++;
			if (stored_cnt > 0)
				stored_cnt--;
			r.pending_bytes = PEND_OUT_W'(stored_cnt);
			release_q = {release_q, r};
			n++;
		end
		if (it.final_segment) begin
			end_seen  = 1'b1;
			limit_idx = it.seg_start_index + seg_pos;
		end
		mid_segment = 1'b0;
		close = end_seen && next_idx == limit_idx;
		if (n == 0) begin
			r               = '0;
			r.stream_close  = close;
			r.pending_bytes = PEND_OUT_W'(stored_cnt);
			r.run_last      = 1'b1;
			release_q = {release_q, r};
		end else begin
			r              = release_q[release_q.size() - 1];
			r.stream_close = close;
			r.run_last     = 1'b1;
			release_q[release_q.size() - 1] = r;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sbr_out_t want;
		if (!arst_n) begin
			foreach (win_present[i])
				win_present[i] = 1'b0;
			next_idx    = '0;
			limit_idx   = '0;
			seg_pos     = '0;
			stored_cnt  = 0;
			end_seen    = 1'b0;
			mid_segment = 1'b0;
			release_q.delete();
			fail_count   = 0;
			results_owed <= 0;
		end else begin
			if (seg_valid && seg_ready)
				reassemble_item(seg);
			if (res_valid && res_ready) begin
				if (release_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result: byte=%02h valid=%0b close=%0b",
						$realtime, res.out_byte, res.out_valid, res.stream_close);
					$display("%0t:   pending=%0d last=%0b",
						$realtime, res.pending_bytes, res.run_last);
				end else begin
					want = release_q[0];
					release_q.delete(0);
					if (res !== want) begin
						fail_count++;
						$display("%0t: expected byte=%02h valid=%0b close=%0b pend=%0d last=%0b",
							$realtime, want.out_byte, want.out_valid, want.stream_close,
							want.pending_bytes, want.run_last);
						$display("%0t: actual   byte=%02h valid=%0b close=%0b pend=%0d last=%0b",
							$realtime, res.out_byte, res.out_valid, res.stream_close,
							res.pending_bytes, res.run_last);
					end
				end
			end
			results_owed <= release_q.size();
		end
	end

endmodule

@@ tb/sv/tb_stream_byte_reassembler_unit.sv @@
// Testbench top for the stream byte reassembler: stimulus, receiver stalls and verdict.
module tb_stream_byte_reassembler_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import sbr_pkg::*;

	typedef logic [7:0] byte_q_t [$];

	localparam int unsigned      DEPTH        = WINDOW_DEPTH_DEF;
	localparam int               RANDOM_ITEMS = 450;
	localparam int               CYCLE_LIMIT  = 200000;
	localparam int               HOLD_CYCLES  = 400;
	// The tail leaves room for one full drain.
	localparam int               TAIL_CYCLES  = 4 + 2 * MAX_RESULTS + 40;
	localparam logic [CAP_W-1:0] CAP_MAX      = CAP_W'(65536);
	localparam logic [CAP_W-1:0] CAP_NONE     = '0;

	logic     clk;
	logic     arst_n;
	logic     seg_valid;
	logic     seg_ready;
	sbr_in_t  seg;
	logic     res_valid;
	logic     res_ready;
	sbr_out_t res;
	int       fail_count;
	int       results_owed;

	int               send_idle_pct    = 34;
	int               recv_idle_pct    = 52;
	int               hold_cycles_left = 0;
	int               data_items       = 0;
	int               cycle_count      = 0;
	// Stimulus-side view of the next index the block waits for. Every episode ends with an
	// in-order fill pass, so this matches the block at each episode boundary.
	logic [IDX_W-1:0] stream_pos;

	stream_byte_reassembler_unit #(.WINDOW_DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_ready (seg_ready),
		.seg       (seg),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	sbr_stream_checker #(.WINDOW_DEPTH(DEPTH)) u_stream_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.seg_valid    (seg_valid),
		.seg_ready    (seg_ready),
		.seg          (seg),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.fail_count   (fail_count),
		.results_owed (results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop: a hung handshake ends the run here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// Receiver: stall at random, or hold off for a long stretch when asked so that the block
	// backs up and drops seg_ready.
	initial begin
		res_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles_left > 0) begin
				res_ready <= 1'b0;
				hold_cycles_left--;
			end else begin
				res_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offer one transaction, idling first at random; return at the edge that accepts it.
	// Valid stays high across back-to-back transactions.
	task automatic send_item(input sbr_in_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			seg_valid <= 1'b0;
			@(posedge clk);
		end
		seg       <= it;
		seg_valid <= 1'b1;
		@(posedge clk);
		while (!seg_ready)
			@(posedge clk);
	endtask

	// Send one segment, one byte per transaction, the end marked on the last. An empty body
	// gives a single empty end item. Capacity counts only on the very first transaction, so
	// later ones carry noise there; fillers with no valid byte may be slipped in.
	task automatic send_segment(input logic [IDX_W-1:0] start, input byte_q_t body,
			input logic [CAP_W-1:0] cap, input logic fin, input int filler_pct);
		sbr_in_t it;
		bit      first;
		int      count;
		first = 1'b1;
		count = (body.size() == 0) ? 1 : body.size();
		for (int k = 0; k < count; k++) begin
			if (k < body.size() && $urandom_range(99) < filler_pct) begin
				it.seg_start_index = start;
				it.data_byte       = 8'($urandom);
				it.byte_valid      = 1'b0;
				it.segment_end     = 1'b0;
				it.final_segment   = 1'($urandom);
				it.avail_capacity  = first ? cap : CAP_W'($urandom_range(65536));
				send_item(it);
				first = 1'b0;
			end
			it.seg_start_index = start;
			it.data_byte       = (k < body.size()) ? body[k] : 8'($urandom);
			it.byte_valid      = (k < body.size());
			it.segment_end     = (k == count - 1);
			it.final_segment   = (k == count - 1) ? fin : 1'($urandom);
			it.avail_capacity  = first ? cap : CAP_W'($urandom_range(65536));
			send_item(it);
			first = 1'b0;
		end
	endtask

	function automatic byte_q_t byte_run(input logic [7:0] seed, input int count,
			input logic [7:0] step);
		byte_q_t q;
		for (int k = 0; k < count; k++)
			q = {q, 8'(seed + 8'(k) * step)};
		return q;
	endfunction

	function automatic byte_q_t take_bytes(input byte_q_t src, input int from, input int count);
		byte_q_t q;
		for (int k = 0; k < count; k++)
			q = {q, src[from + k]};
		return q;
	endfunction

	// Random capacity that never narrows the window below its depth.
	function automatic logic [CAP_W-1:0] roomy_cap();
		return CAP_W'($urandom_range(65536, DEPTH));
	endfunction

	// Segment that the block must drop: far ahead of the window, stale (possibly wrapping
	// through zero), or at least twice the window depth ahead.
	task automatic send_noise();
		byte_q_t          junk;
		logic [IDX_W-1:0] start;
		repeat ($urandom_range(3))
			junk = {junk, 8'($urandom)};
		case ($urandom_range(2))
			0:       start = {$urandom, $urandom} | {1'b1, {(IDX_W-1){1'b0}}};
			1:       start = stream_pos - junk.size() - $urandom_range(40);
			default: start = stream_pos + 2 * DEPTH + $urandom_range(200);
		endcase
		send_segment(start, junk, CAP_W'($urandom_range(65536)), 1'b0, 10);
	endtask

	// One stretch of the stream: chop it into pieces, add overlapping duplicates, send them
	// shuffled with noise in between, then send it once more in order so the stream is
	// complete up to its end whatever the shuffled pass lost to small capacity.
	task automatic run_episode(input int len);
		byte_q_t stream_bytes;
		int      cuts [$];
		int      lens [$];
		int      order [$];
		int      pos;
		int      plen;
		int      j;
		int      tmp;
		logic [CAP_W-1:0] cap;
		repeat (len)
			stream_bytes = {stream_bytes, 8'($urandom)};
		pos = 0;
		while (pos < len) begin
			plen = $urandom_range(8, 1);
			if (plen > len - pos)
				plen = len - pos;
			cuts = {cuts, pos};
			lens = {lens, plen};
			pos += plen;
		end
		repeat ($urandom_range(2)) begin
			pos  = $urandom_range(len - 1);
			plen = $urandom_range(6, 1);
			if (plen > len - pos)
				plen = len - pos;
			cuts = {cuts, pos};
			lens = {lens, plen};
		end
		foreach (cuts[i])
			order = {order, i};
		for (int i = order.size() - 1; i > 0; i--) begin
			j        = $urandom_range(i);
			tmp      = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		foreach (order[i]) begin
			if ($urandom_range(99) < 12)
				send_noise();
			cap = ($urandom_range(99) < 80) ? roomy_cap() : CAP_W'($urandom_range(80));
			send_segment(stream_pos + cuts[order[i]],
				take_bytes(stream_bytes, cuts[order[i]], lens[order[i]]), cap, 1'b0, 5);
			data_items += lens[order[i]];
		end
		pos = 0;
		while (pos < len) begin
			plen = $urandom_range(8, 1);
			if (plen > len - pos)
				plen = len - pos;
			send_segment(stream_pos + pos, take_bytes(stream_bytes, pos, plen),
				roomy_cap(), 1'b0, 5);
			data_items += plen;
			pos += plen;
		end
		stream_pos += len;
	endtask

	initial begin
		byte_q_t tail_bytes;
		byte_q_t none;
		bit      pressure_done;
		int      len;
		pressure_done = 1'b0;
		arst_n        = 1'b0;
		seg_valid     = 1'b0;
		seg           = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, starting from an empty window at index zero.
		// Advance through the top of the index space: the first two bytes sit above the
		// window, the last two wrap to indexes zero and one and drain at once.
		send_segment({IDX_W{1'b1}} - 1, byte_run(8'h00, 4, 8'h55), CAP_MAX, 1'b0, 0);
		// Empty segment with nothing to release: status only.
		send_segment(64'd2, none, CAP_NONE, 1'b0, 0);
		// Zero capacity: the window is empty, drop both bytes.
		send_segment(64'd2, byte_run(8'h11, 2, 8'h01), CAP_NONE, 1'b0, 0);
		// Out of order: hold two bytes ahead of a gap.
		send_segment(64'd5, byte_run(8'h35, 2, 8'h01), CAP_W'(10), 1'b0, 0);
		// Duplicate of a held byte: ignore it.
		send_segment(64'd6, byte_run(8'hC3, 1, 8'h00), CAP_W'(10), 1'b0, 0);
		// Capacity edge: keep index 7, drop 8 and 9 beyond the limit.
		send_segment(64'd7, byte_run(8'h70, 3, 8'h01), CAP_W'(6), 1'b0, 0);
		// Window depth edge: the last slot of the window is kept, one past it is dropped.
		send_segment(64'd2 + DEPTH - 1, byte_run(8'hE1, 1, 8'h00), CAP_MAX, 1'b0, 0);
		send_segment(64'd2 + DEPTH, byte_run(8'hE2, 1, 8'h00), CAP_MAX, 1'b0, 0);
		// Partly stale segment: drop indexes 0 and 1, fill the gap and drain through 7.
		send_segment(64'd0, byte_run(8'hF0, 5, 8'h03), CAP_MAX, 1'b0, 0);
		stream_pos = 64'd8;

		// Random part: sender and receiver idle by phase, then neither; the long receiver
		// hold-off lands at the start of the no-idle phase while the sender keeps offering.
		while (data_items < RANDOM_ITEMS) begin
			if (data_items < RANDOM_ITEMS / 3) begin
				send_idle_pct = 34;
				recv_idle_pct = 52;
			end else if (data_items < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 52;
				recv_idle_pct = 34;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				if (!pressure_done) begin
					hold_cycles_left = HOLD_CYCLES;
					pressure_done    = 1'b1;
				end
			end
			// Mostly short stretches, a few long ones of up to the whole window depth.
			len = ($urandom_range(99) < 15) ? $urandom_range(DEPTH, 25) : $urandom_range(24, 1);
			run_episode(len);
		end

		// Close the stream, the final segment arriving ahead of a gap.
		send_idle_pct = 20;
		recv_idle_pct = 20;
		repeat (5)
			tail_bytes = {tail_bytes, 8'($urandom)};
		send_segment(stream_pos + 3, take_bytes(tail_bytes, 3, 2), roomy_cap(), 1'b1, 0);
		// Past the known end: drop it.
		send_segment(stream_pos + 5, byte_run(8'h99, 1, 8'h00), CAP_MAX, 1'b0, 0);
		// Fill the gap: drain to the end and flag the close.
		send_segment(stream_pos, take_bytes(tail_bytes, 0, 3), roomy_cap(), 1'b0, 0);
		// Closed stream: every further end item flags the close again.
		send_segment(stream_pos + 5, none, CAP_NONE, 1'b0, 0);
		send_noise();

		seg_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && results_owed == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/sbr_pkg.sv
rtl/core/sbr_ram.sv
rtl/core/sbr_front.sv
rtl/core/sbr_cmd_fifo.sv
rtl/core/sbr_back.sv
rtl/core/stream_byte_reassembler_unit.sv
tb/sv/sbr_stream_checker.sv
tb/sv/tb_stream_byte_reassembler_unit.sv
